[sv/wst_pkg.sv]
// ----------------------------------------------------------------------------
// wst_pkg
// shared types and constants of the whitespace tokenizer
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam logic       KIND_TEXT  = 1'b0;
  localparam logic       KIND_END   = 1'b1;

  localparam logic       RES_WORD   = 1'b0;
  localparam logic       RES_MARK   = 1'b1;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int         QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_SEP,
    OP_NEWLINE,
    OP_END
  } op_t;

  // one classified input item
  typedef struct packed {
    logic       start;
    op_t        op;
    logic [7:0] text_byte;
  } cmd_t;

endpackage

[sv/wst_if.sv]
// ----------------------------------------------------------------------------
// wst_in_if / wst_out_if
// valid/ready channels of the whitespace tokenizer
// ----------------------------------------------------------------------------
interface wst_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface wst_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] word_byte;
  logic       word_end;
  logic       run_last;

  modport source (output valid, output result_kind, output word_byte,
                  output word_end, output run_last, input ready);
  modport sink   (input valid, input result_kind, input word_byte,
                  input word_end, input run_last, output ready);
endinterface

[sv/whitespace_tokenizer.sv]
// ----------------------------------------------------------------------------
// whitespace_tokenizer
// splits a byte stream into words and paragraph markers
//
//   channel    dir  payload
//   byte_ch    in   kind, text_byte
//   result_ch  out  result_kind, word_byte, word_end, run_last
//
// a plain text byte retires straight from the queue head once it reaches
// the back end; a separator ending a word walks the stored bytes in turn,
// since each stored byte needs a registered word-store read and then an
// output load. each paragraph marker takes an output load of its own. a
// two-entry queue lets the front take new beats while a word drains. reset
// is synchronous and needs no clearing pass; a stall on result_ch holds the
// output register and backs up into the queue.
// ----------------------------------------------------------------------------
module whitespace_tokenizer #(
  parameter int MAX_TOKEN = 32
) (
  input  logic      clk,
  input  logic      rst,
  wst_in_if.sink    byte_ch,
  wst_out_if.source result_ch
);

  logic          push;
  logic          push_ready;
  wst_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop;
  wst_pkg::cmd_t pop_cmd;

  wst_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .q_ready (push_ready),
    .q_push  (push),
    .q_cmd   (push_cmd)
  );

  wst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  wst_back #(
    .MAX_TOKEN (MAX_TOKEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .result_ch (result_ch)
  );

endmodule

[sv/wst_front.sv]
// ----------------------------------------------------------------------------
// wst_front
// accepts input beats, classifies each byte and tracks stream start
// ----------------------------------------------------------------------------
module wst_front (
  input  logic          clk,
  input  logic          rst,
  wst_in_if.sink        byte_ch,
  input  logic          q_ready,
  output logic          q_push,
  output wst_pkg::cmd_t q_cmd
);

  logic at_stream_start;

  assign byte_ch.ready = q_ready;
  assign q_push        = byte_ch.valid && q_ready;

  always_comb begin
    q_cmd.start     = at_stream_start;
    q_cmd.text_byte = byte_ch.text_byte;
    if (byte_ch.kind == wst_pkg::KIND_END) begin
      q_cmd.op = wst_pkg::OP_END;
    end else if (byte_ch.text_byte == wst_pkg::CH_SPACE ||
                 byte_ch.text_byte == wst_pkg::CH_TAB) begin
      q_cmd.op = wst_pkg::OP_SEP;
    end else if (byte_ch.text_byte == wst_pkg::CH_NEWLINE) begin
      q_cmd.op = wst_pkg::OP_NEWLINE;
    end else begin
      q_cmd.op = wst_pkg::OP_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_stream_start <= 1'b1;
    end else if (q_push) begin
      at_stream_start <= (byte_ch.kind == wst_pkg::KIND_END);
    end
  end

endmodule

[sv/wst_queue.sv]
// ----------------------------------------------------------------------------
// wst_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module wst_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wst_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output wst_pkg::cmd_t pop_cmd,
  input  logic          pop
);

  localparam int PTR_W = (wst_pkg::QUEUE_DEPTH > 1) ? $clog2(wst_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(wst_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(wst_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(wst_pkg::QUEUE_DEPTH - 1);

  wst_pkg::cmd_t    entries [wst_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[sv/wst_back.sv]
// ----------------------------------------------------------------------------
// wst_back
// word store, length tracking and result sequencing
// ----------------------------------------------------------------------------
module wst_back #(
  parameter int MAX_TOKEN = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  wst_pkg::cmd_t q_cmd,
  output logic          q_pop,
  wst_out_if.source     result_ch
);

  localparam int LEN_W = $clog2(MAX_TOKEN + 2);
  localparam int IDX_W = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_TOKEN);
  localparam logic [LEN_W-1:0] OVER_LEN = LEN_W'(MAX_TOKEN + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_BODY,
    S_READ,
    S_EMIT,
    S_MARK_NL
  } state_t;

  state_t           state;
  wst_pkg::cmd_t    cur;
  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] idx;
  logic [7:0]       mem [MAX_TOKEN];
  logic [7:0]       rd_data;

  logic             out_valid;
  logic             out_kind;
  logic [7:0]       out_byte;
  logic             out_end;
  logic             out_last;

  logic             out_free;
  logic             word_emit;
  logic             idx_last;
  logic             fast_byte;
  logic             fast_skip;
  logic             store_now;
  logic [7:0]       store_byte;
  logic             mem_we;
  logic [LEN_W-1:0] len_stored;

  assign result_ch.valid       = out_valid;
  assign result_ch.result_kind = out_kind;
  assign result_ch.word_byte   = out_byte;
  assign result_ch.word_end    = out_end;
  assign result_ch.run_last    = out_last;

  assign out_free  = !out_valid || result_ch.ready;
  assign word_emit = (len != '0) && (len <= MAX_LEN);
  assign idx_last  = (LEN_W'(idx) + LEN_W'(1)) == len;

  // plain bytes and idle separators retire straight from the queue head
  assign fast_byte = !q_cmd.start && (q_cmd.op == wst_pkg::OP_BYTE);
  assign fast_skip = !q_cmd.start && (q_cmd.op == wst_pkg::OP_SEP) && !word_emit;
  assign q_pop     = (state == S_IDLE) && q_valid;

  assign store_now  = (q_pop && fast_byte) ||
                      (state == S_BODY && cur.op == wst_pkg::OP_BYTE);
  assign store_byte = (state == S_IDLE) ? q_cmd.text_byte : cur.text_byte;
  assign mem_we     = store_now && (len < MAX_LEN);
  // saturate one past the limit to flag an overlong word
  assign len_stored = (len < MAX_LEN) ? len + LEN_W'(1) : OVER_LEN;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[len[IDX_W-1:0]] <= store_byte;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_cmd;
            if (fast_byte) begin
              len <= len_stored;
            end else if (fast_skip) begin
              len <= '0;
            end else begin
              state <= q_cmd.start ? S_START : S_BODY;
            end
          end
        end
        S_START: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= wst_pkg::RES_MARK;
            out_byte  <= '0;
            out_end   <= 1'b0;
            out_last  <= (cur.op == wst_pkg::OP_BYTE) ||
                         (cur.op == wst_pkg::OP_SEP && !word_emit);
            state     <= S_BODY;
          end
        end
        S_BODY: begin
          case (cur.op)
            wst_pkg::OP_BYTE: begin
              len   <= len_stored;
              state <= S_IDLE;
            end
            wst_pkg::OP_END: begin
              if (out_free) begin
                out_valid <= 1'b1;
                out_kind  <= wst_pkg::RES_MARK;
                out_byte  <= '0;
                out_end   <= 1'b0;
                out_last  <= 1'b1;
                len       <= '0;
                state     <= S_IDLE;
              end
            end
            default: begin
              if (word_emit) begin
                idx   <= '0;
                state <= S_READ;
              end else begin
                len   <= '0;
                state <= (cur.op == wst_pkg::OP_NEWLINE) ? S_MARK_NL : S_IDLE;
              end
            end
          endcase
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= wst_pkg::RES_WORD;
            out_byte  <= rd_data;
            out_end   <= idx_last;
            out_last  <= idx_last && (cur.op != wst_pkg::OP_NEWLINE);
            if (idx_last) begin
              len   <= '0;
              state <= (cur.op == wst_pkg::OP_NEWLINE) ? S_MARK_NL : S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_READ;
            end
          end
        end
        S_MARK_NL: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= wst_pkg::RES_MARK;
            out_byte  <= '0;
            out_end   <= 1'b0;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/whitespace_tokenizer_tb.sv]
// ----------------------------------------------------------------------------
// whitespace_tokenizer_tb
// self-checking bench for the whitespace tokenizer: a directed table of
// extremes and corner cases, then random text of words, separators and end
// marks, checked against a cycle-free prediction of every result beat under
// random sender bursts and receiver stalls
// ----------------------------------------------------------------------------
module whitespace_tokenizer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TOKEN   = 32;
  localparam int IDX_W       = $clog2(MAX_TOKEN);
  localparam int BY_MODEL    = -1;
  localparam int RAND_BEATS  = 270;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] word_byte;
    logic       word_end;
    logic       run_last;
  } token_t;

  // one line of the directed table; marks is the number of markers expected
  // per beat, or BY_MODEL when the prediction decides
  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
    int         reps;
    int         marks;
  } stim_row_t;

  logic clk;
  logic rst;

  wst_in_if  byte_ch ();
  wst_out_if result_ch ();

  whitespace_tokenizer #(
    .MAX_TOKEN(MAX_TOKEN)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .result_ch(result_ch)
  );

  // prediction state
  logic       at_start;
  logic [7:0] word_mem [MAX_TOKEN];
  logic [5:0] word_len;
  token_t     beat_tokens[$];
  token_t     pending_tokens[$];

  stim_row_t  script[$];
  int         marks_now;
  int         mismatches;
  int         beats_sent;
  int         burst_left;
  int         hold_asked;
  int         hold_served;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic is_sep(input logic [7:0] c);
    return c == wst_pkg::CH_SPACE || c == wst_pkg::CH_TAB || c == wst_pkg::CH_NEWLINE;
  endfunction

  function automatic void emit(input logic rk, input logic [7:0] b, input logic we);
    token_t t;
    t.result_kind = rk;
    t.word_byte   = b;
    t.word_end    = we;
    t.run_last    = 1'b0;
    beat_tokens.push_back(t);
  endfunction

  // results of one accepted beat, into beat_tokens
  function automatic void tokenize_beat(input logic k, input logic [7:0] b);
    beat_tokens.delete();
    if (at_start) begin
      emit(wst_pkg::RES_MARK, 8'h00, 1'b0);
      at_start = 1'b0;
    end
    if (k == wst_pkg::KIND_END) begin
      word_len = '0;
      emit(wst_pkg::RES_MARK, 8'h00, 1'b0);
      at_start = 1'b1;
    end else if (is_sep(b)) begin
      if (word_len >= 1 && word_len <= MAX_TOKEN) begin
        for (int i = 0; i < word_len; i++)
          emit(wst_pkg::RES_WORD, word_mem[i], (i + 1) == word_len);
      end
      word_len = '0;
      if (b == wst_pkg::CH_NEWLINE)
        emit(wst_pkg::RES_MARK, 8'h00, 1'b0);
    end else if (word_len < MAX_TOKEN) begin
      word_mem[word_len[IDX_W-1:0]] = b;
      word_len = word_len + 1'b1;
    end else begin
      // overlong word: length parks one past the limit
      word_len = 6'(MAX_TOKEN + 1);
    end
  endfunction

  always @(posedge clk) begin
    token_t t;
    token_t e;
    int     n;
    if (rst) begin
      at_start = 1'b1;
      word_len = '0;
      for (int i = 0; i < MAX_TOKEN; i++)
        word_mem[i] = 8'h00;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        tokenize_beat(byte_ch.kind, byte_ch.text_byte);
        if (marks_now != BY_MODEL) begin
          beat_tokens.delete();
          for (int i = 0; i < marks_now; i++)
            emit(wst_pkg::RES_MARK, 8'h00, 1'b0);
        end
        n = beat_tokens.size();
        for (int i = 0; i < n; i++) begin
          t = beat_tokens[i];
          t.run_last = (i == n - 1);
          pending_tokens.push_back(t);
        end
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_tokens.size() == 0) begin
          $error("unexpected result beat: kind %0d byte %02h",
                 result_ch.result_kind, result_ch.word_byte);
          mismatches++;
        end else begin
          e = pending_tokens.pop_front();
          if (result_ch.result_kind !== e.result_kind) begin
            $error("result_kind: expected %0d, got %0d", e.result_kind, result_ch.result_kind);
            mismatches++;
          end
          if (result_ch.word_byte !== e.word_byte) begin
            $error("word_byte: expected %02h, got %02h", e.word_byte, result_ch.word_byte);
            mismatches++;
          end
          if (result_ch.word_end !== e.word_end) begin
            $error("word_end: expected %0d, got %0d", e.word_end, result_ch.word_end);
            mismatches++;
          end
          if (result_ch.run_last !== e.run_last) begin
            $error("run_last: expected %0d, got %0d", e.run_last, result_ch.run_last);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver: stall pattern of its own, plus one long hold on request
  initial begin
    int mode;
    int seg;
    result_ch.ready = 1'b0;
    forever begin
      if (hold_served < hold_asked) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          result_ch.ready <= 1'b0;
        end
        hold_served++;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(8, 60);
        repeat (seg) begin
          @(negedge clk);
          case (mode)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= 1'($urandom_range(0, 1));
            2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
            default: result_ch.ready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  task automatic offer(input logic k, input logic [7:0] b, input int marks);
    @(negedge clk);
    byte_ch.valid     <= 1'b1;
    byte_ch.kind      <= k;
    byte_ch.text_byte <= b;
    marks_now         <= marks;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  // sender works in bursts with random gaps between them
  task automatic send_beat(input logic k, input logic [7:0] b, input int marks);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        byte_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    offer(k, b, marks);
    beats_sent++;
  endtask

  task automatic wait_drained();
    while (pending_tokens.size() != 0) @(negedge clk);
  endtask

  function automatic void row(input logic k, input logic [7:0] b, input int reps,
                              input int marks);
    stim_row_t r;
    r.kind      = k;
    r.text_byte = b;
    r.reps      = reps;
    r.marks     = marks;
    script.push_back(r);
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_sep(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] any_sep();
    case ($urandom_range(0, 2))
      0:       return wst_pkg::CH_SPACE;
      1:       return wst_pkg::CH_TAB;
      default: return wst_pkg::CH_NEWLINE;
    endcase
  endfunction

  initial begin
    stim_row_t r;
    int        rand_base;
    int        len;
    int        pick;
    logic      held;
    logic      paused;

    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.kind      = wst_pkg::KIND_TEXT;
    byte_ch.text_byte = 8'h00;
    marks_now         = BY_MODEL;
    mismatches        = 0;
    beats_sent        = 0;
    burst_left        = 0;
    hold_asked        = 0;
    hold_served       = 0;
    held              = 1'b0;
    paused            = 1'b0;

    //  kind                byte                 reps            markers
    row(wst_pkg::KIND_END,  8'h00,               1,              2); // end as very first beat
    row(wst_pkg::KIND_TEXT, wst_pkg::CH_SPACE,   1,              1); // start marker, no word
    row(wst_pkg::KIND_TEXT, wst_pkg::CH_NEWLINE, 1,              1); // newline with no word
    row(wst_pkg::KIND_TEXT, wst_pkg::CH_TAB,     1,              0); // repeated separator
    row(wst_pkg::KIND_TEXT, 8'h00,               1,              0); // nul is a word byte
    row(wst_pkg::KIND_TEXT, 8'hFF,               1,              0);
    row(wst_pkg::KIND_TEXT, 8'h41,               1,              0);
    row(wst_pkg::KIND_TEXT, wst_pkg::CH_SPACE,   1,              BY_MODEL);
    row(wst_pkg::KIND_TEXT, 8'h80,               MAX_TOKEN,      0); // longest word kept
    row(wst_pkg::KIND_TEXT, wst_pkg::CH_TAB,     1,              BY_MODEL);
    row(wst_pkg::KIND_TEXT, 8'h61,               MAX_TOKEN + 1,  0); // one byte too long
    row(wst_pkg::KIND_TEXT, wst_pkg::CH_NEWLINE, 1,              1); // overlong, marker only
    row(wst_pkg::KIND_TEXT, 8'h7E,               MAX_TOKEN + 13, 0); // length saturates
    row(wst_pkg::KIND_TEXT, wst_pkg::CH_SPACE,   1,              0);
    row(wst_pkg::KIND_TEXT, 8'h62,               3,              0);
    row(wst_pkg::KIND_END,  8'hFF,               1,              1); // partial word dropped
    row(wst_pkg::KIND_TEXT, 8'h63,               1,              1); // start marker again
    row(wst_pkg::KIND_TEXT, wst_pkg::CH_NEWLINE, 1,              BY_MODEL); // word and marker
    row(wst_pkg::KIND_TEXT, 8'h01,               1,              0);
    row(wst_pkg::KIND_TEXT, 8'h7F,               1,              0);
    row(wst_pkg::KIND_TEXT, 8'h0B,               1,              0); // separator neighbors
    row(wst_pkg::KIND_TEXT, 8'h0D,               1,              0);
    row(wst_pkg::KIND_TEXT, 8'h1F,               1,              0);
    row(wst_pkg::KIND_TEXT, 8'h21,               1,              0);
    row(wst_pkg::KIND_TEXT, wst_pkg::CH_NEWLINE, 1,              BY_MODEL);
    row(wst_pkg::KIND_END,  8'hA5,               1,              1);

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      r = script[i];
      repeat (r.reps) send_beat(r.kind, r.text_byte, r.marks);
    end
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    wait_drained();

    rand_base = beats_sent;
    while (beats_sent - rand_base < RAND_BEATS) begin
      if (!held && beats_sent - rand_base > 60) begin
        hold_asked++;
        held = 1'b1;
      end
      if (!paused && beats_sent - rand_base > 170) begin
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_beat(wst_pkg::KIND_END, 8'($urandom_range(0, 255)), BY_MODEL);
      end else if (pick < 10) begin
        // noise: any byte at all
        send_beat(wst_pkg::KIND_TEXT, 8'($urandom_range(0, 255)), BY_MODEL);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          len = $urandom_range(MAX_TOKEN - 2, MAX_TOKEN + 4);
        else if (pick < 10)
          len = $urandom_range(MAX_TOKEN + 5, MAX_TOKEN + 18);
        else
          len = $urandom_range(1, 10);
        repeat (len) send_beat(wst_pkg::KIND_TEXT, word_char(), BY_MODEL);
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          // broken word: cut off by end of input
          send_beat(wst_pkg::KIND_END, 8'($urandom_range(0, 255)), BY_MODEL);
        end else begin
          send_beat(wst_pkg::KIND_TEXT, any_sep(), BY_MODEL);
          if (pick < 20)
            send_beat(wst_pkg::KIND_TEXT, any_sep(), BY_MODEL);
        end
      end
    end

    @(negedge clk);
    byte_ch.valid <= 1'b0;
    wait_drained();
    repeat (100) @(negedge clk);

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
